### sv/rpr_pkg.sv
// shared types and constants for the radar point residual unit
package rpr_pkg;

  localparam int unsigned COORD_W     = 32;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned IN_W        = 5 * COORD_W;
  localparam int unsigned OUT_W       = 2 * COORD_W;
  localparam int unsigned USER_W      = 2;
  localparam int unsigned SQRT_STEPS  = 32;
  localparam int unsigned DIV_STEPS   = 41;
  localparam int unsigned PIPE_DEPTH  = 6 + SQRT_STEPS + 2 + DIV_STEPS + 1;

  localparam logic [CFG_IDX_W-1:0] REG_QUAT_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUAT_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_QUAT_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_QUAT_W  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Z = 3'd6;

  localparam logic signed [31:0] Q30_ONE    = 32'sh4000_0000;
  localparam logic [40:0]        PROJ_LIMIT = 41'h100_0000_0000;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic [31:0] mag_x;
    logic [31:0] mag_y;
    logic        neg_x;
    logic        neg_y;
    coord_t      meas_x;
    coord_t      meas_y;
    logic        degen;
    logic        sat;
  } sq_side_t;

  typedef struct packed {
    logic   neg_x;
    logic   neg_y;
    coord_t meas_x;
    coord_t meas_y;
    logic   degen;
    logic   sat;
    logic   ovf_x;
    logic   ovf_y;
  } dv_side_t;

endpackage

### sv/rpr_rotate.sv
// rotation matrix from the quaternion, matrix times point plus translation
module rpr_rotate (
  input  logic                  clk,
  input  logic                  en,
  input  rpr_pkg::coord_t [3:0] quat,
  input  rpr_pkg::coord_t [2:0] shift,
  input  rpr_pkg::coord_t [2:0] point,
  output rpr_pkg::coord_t [2:0] moved,
  output logic                  sat
);
  import rpr_pkg::*;

  function automatic logic signed [31:0] qmul(input logic [30:0] a, input logic [30:0] b,
                                              input logic neg);
    logic [61:0] m;
    logic [31:0] r;
    m = {31'b0, a} * {31'b0, b};
    r = 32'((m + (62'd1 << 29)) >> 30);
    return neg ? -$signed(r) : $signed(r);
  endfunction

  logic [30:0] qmag [4];
  logic        qneg [4];
  coord_t      qc   [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (quat[i] > Q30_ONE) qc[i] = Q30_ONE;
      else if (quat[i] < -Q30_ONE) qc[i] = -Q30_ONE;
      else qc[i] = quat[i];
      qneg[i] = qc[i][31];
      qmag[i] = qc[i][31] ? 31'(-qc[i]) : qc[i][30:0];
    end
  end

  // quaternion products, x=0 y=1 z=2 w=3
  logic signed [31:0] xx, yy, zz, xy, xz, yz, xw, yw, zw;

  always_ff @(posedge clk) begin
    xx <= qmul(qmag[0], qmag[0], 1'b0);
    yy <= qmul(qmag[1], qmag[1], 1'b0);
    zz <= qmul(qmag[2], qmag[2], 1'b0);
    xy <= qmul(qmag[0], qmag[1], qneg[0] ^ qneg[1]);
    xz <= qmul(qmag[0], qmag[2], qneg[0] ^ qneg[2]);
    yz <= qmul(qmag[1], qmag[2], qneg[1] ^ qneg[2]);
    xw <= qmul(qmag[0], qmag[3], qneg[0] ^ qneg[3]);
    yw <= qmul(qmag[1], qmag[3], qneg[1] ^ qneg[3]);
    zw <= qmul(qmag[2], qmag[3], qneg[2] ^ qneg[3]);
  end

  logic signed [34:0] ent [9];
  logic signed [34:0] one35;
  logic [32:0]        ment_mag [9];
  logic               ment_neg [9];

  assign one35 = 35'(Q30_ONE);

  always_comb begin
    ent[0] = one35 - 35'sd2 * (35'(yy) + 35'(zz));
    ent[1] = 35'sd2 * (35'(xy) - 35'(zw));
    ent[2] = 35'sd2 * (35'(xz) + 35'(yw));
    ent[3] = 35'sd2 * (35'(xy) + 35'(zw));
    ent[4] = one35 - 35'sd2 * (35'(xx) + 35'(zz));
    ent[5] = 35'sd2 * (35'(yz) - 35'(xw));
    ent[6] = 35'sd2 * (35'(xz) - 35'(yw));
    ent[7] = 35'sd2 * (35'(yz) + 35'(xw));
    ent[8] = one35 - 35'sd2 * (35'(xx) + 35'(yy));
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 9; k++) begin
      ment_neg[k] <= ent[k][34];
      ment_mag[k] <= ent[k][34] ? 33'(-ent[k]) : ent[k][32:0];
    end
  end

  // one stage of delay so the matrix follows a fresh register write
  coord_t [2:0] pt1;
  always_ff @(posedge clk) begin
    if (en) pt1 <= point;
  end

  logic [31:0]        vmag [3];
  logic signed [35:0] term_next [9];
  logic signed [35:0] term      [9];

  always_comb begin
    logic [64:0] pr;
    logic [34:0] rm;
    pr = '0;
    rm = '0;
    for (int j = 0; j < 3; j++) vmag[j] = pt1[j][31] ? 32'(-pt1[j]) : 32'(pt1[j]);
    for (int k = 0; k < 9; k++) begin
      pr = {32'b0, ment_mag[k]} * {33'b0, vmag[k % 3]};
      rm = 35'((pr + (65'd1 << 29)) >> 30);
      term_next[k] = (ment_neg[k] ^ pt1[k % 3][31]) ? -$signed({1'b0, rm})
                                                    : $signed({1'b0, rm});
    end
  end

  always_ff @(posedge clk) begin
    if (en) term <= term_next;
  end

  logic signed [37:0] acc [3];
  logic [2:0]         clip;
  coord_t [2:0]       moved_next;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = 38'(shift[i]) + 38'(term[3*i]) + 38'(term[3*i+1]) + 38'(term[3*i+2]);
      clip[i] = 1'b0;
      if (acc[i] > 38'sd2147483647) begin
        moved_next[i] = 32'sh7fff_ffff;
        clip[i] = 1'b1;
      end else if (acc[i] < -38'sd2147483648) begin
        moved_next[i] = 32'sh8000_0000;
        clip[i] = 1'b1;
      end else begin
        moved_next[i] = acc[i][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      moved <= moved_next;
      sat   <= |clip;
    end
  end

endmodule

### sv/rpr_sqrt_cell.sv
// one bit of a pipelined integer square root
module rpr_sqrt_cell #(
  parameter int BIT = 0
) (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] rem_in,
  input  logic [31:0] root_in,
  output logic [63:0] rem_out,
  output logic [31:0] root_out
);

  logic [64:0] trial;
  logic        take;

  assign trial = ({33'b0, root_in} << (BIT + 1)) + (65'd1 << (2 * BIT));
  assign take  = {1'b0, rem_in} >= trial;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out  <= take ? 64'({1'b0, rem_in} - trial) : rem_in;
      root_out <= take ? (root_in | (32'd1 << BIT)) : root_in;
    end
  end

endmodule

### sv/rpr_div_cell.sv
// one quotient bit of a pipelined restoring divider
module rpr_div_cell #(
  parameter int BIT = 0
) (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] den_in,
  input  logic [63:0] rem_in,
  input  logic [40:0] quo_in,
  output logic [31:0] den_out,
  output logic [63:0] rem_out,
  output logic [40:0] quo_out
);

  logic [72:0] sub;
  logic        take;

  assign sub  = {41'b0, den_in} << BIT;
  assign take = {9'b0, rem_in} >= sub;

  always_ff @(posedge clk) begin
    if (en) begin
      den_out <= den_in;
      rem_out <= take ? 64'({9'b0, rem_in} - sub) : rem_in;
      quo_out <= take ? (quo_in | (41'd1 << BIT)) : quo_in;
    end
  end

endmodule

### sv/radar_point_residual_unit.sv
// top level: point transform, range and planar distance, residual per item
//
// channel  | valid / ready                  | payload
// ---------+--------------------------------+-------------------------------
// in       | s_axis_tvalid / s_axis_tready  | s_axis_tdata, 160 bits
// out      | m_axis_tvalid / m_axis_tready  | m_axis_tdata 64, m_axis_tuser 2
// config   | cfg_we                         | cfg_index, cfg_data
//
// one item per cycle while no result waits in the skid register
// the pipe holds two chains of 32 square root cells and two chains of 41 divider cells
// a skid register behind the output takes one result while the pipe stalls
// rst clears the valid bits and loads the identity quaternion, zero shift
module radar_point_residual_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [rpr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // point_x, point_y, point_z, meas_x, meas_y
  input  logic [rpr_pkg::IN_W-1:0]      s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // residual_x, residual_y
  output logic [rpr_pkg::OUT_W-1:0]     m_axis_tdata,
  // degenerate, saturated
  output logic [rpr_pkg::USER_W-1:0]    m_axis_tuser
);
  import rpr_pkg::*;

  coord_t [3:0] quat;
  coord_t [2:0] shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      quat  <= {Q30_ONE, 32'sd0, 32'sd0, 32'sd0};
      shift <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_QUAT_X:  quat[0]  <= cfg_data;
        REG_QUAT_Y:  quat[1]  <= cfg_data;
        REG_QUAT_Z:  quat[2]  <= cfg_data;
        REG_QUAT_W:  quat[3]  <= cfg_data;
        REG_SHIFT_X: shift[0] <= cfg_data;
        REG_SHIFT_Y: shift[1] <= cfg_data;
        REG_SHIFT_Z: shift[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  logic                  en;
  logic                  skid_v;
  logic [PIPE_DEPTH-1:0] vld;

  assign en            = !skid_v;
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[PIPE_DEPTH-2:0], s_axis_tvalid};
  end

  // input stage
  coord_t [2:0] pt0;
  coord_t       meas0_x, meas0_y;

  always_ff @(posedge clk) begin
    if (en) begin
      pt0[0]  <= s_axis_tdata[31:0];
      pt0[1]  <= s_axis_tdata[63:32];
      pt0[2]  <= s_axis_tdata[95:64];
      meas0_x <= s_axis_tdata[127:96];
      meas0_y <= s_axis_tdata[159:128];
    end
  end

  coord_t [2:0] moved;
  logic         rot_sat;

  rpr_rotate u_rotate (
    .clk   (clk),
    .en    (en),
    .quat  (quat),
    .shift (shift),
    .point (pt0),
    .moved (moved),
    .sat   (rot_sat)
  );

  coord_t meas_dx [3];
  coord_t meas_dy [3];

  always_ff @(posedge clk) begin
    if (en) begin
      meas_dx[0] <= meas0_x;
      meas_dy[0] <= meas0_y;
      for (int i = 1; i < 3; i++) begin
        meas_dx[i] <= meas_dx[i-1];
        meas_dy[i] <= meas_dy[i-1];
      end
    end
  end

  // squares
  logic [31:0] mag_z;
  logic [63:0] sq_x, sq_y, sq_z;
  sq_side_t    side4, side5;
  logic [63:0] d2, r2;

  assign mag_z = moved[2][31] ? 32'(-moved[2]) : 32'(moved[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      side4.mag_x  <= moved[0][31] ? 32'(-moved[0]) : 32'(moved[0]);
      side4.mag_y  <= moved[1][31] ? 32'(-moved[1]) : 32'(moved[1]);
      side4.neg_x  <= moved[0][31];
      side4.neg_y  <= moved[1][31];
      side4.meas_x <= meas_dx[2];
      side4.meas_y <= meas_dy[2];
      side4.degen  <= 1'b0;
      side4.sat    <= rot_sat;
      sq_x <= {32'b0, (moved[0][31] ? 32'(-moved[0]) : 32'(moved[0]))}
            * {32'b0, (moved[0][31] ? 32'(-moved[0]) : 32'(moved[0]))};
      sq_y <= {32'b0, (moved[1][31] ? 32'(-moved[1]) : 32'(moved[1]))}
            * {32'b0, (moved[1][31] ? 32'(-moved[1]) : 32'(moved[1]))};
      sq_z <= {32'b0, mag_z} * {32'b0, mag_z};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d2           <= sq_x + sq_y;
      r2           <= sq_x + sq_y + sq_z;
      side5.mag_x  <= side4.mag_x;
      side5.mag_y  <= side4.mag_y;
      side5.neg_x  <= side4.neg_x;
      side5.neg_y  <= side4.neg_y;
      side5.meas_x <= side4.meas_x;
      side5.meas_y <= side4.meas_y;
      side5.degen  <= (sq_x + sq_y) == 64'd0;
      side5.sat    <= side4.sat;
    end
  end

  // square root chains for range and planar distance
  logic [63:0] rr_rem  [SQRT_STEPS+1];
  logic [31:0] rr_root [SQRT_STEPS+1];
  logic [63:0] dd_rem  [SQRT_STEPS+1];
  logic [31:0] dd_root [SQRT_STEPS+1];
  sq_side_t    sq_side [SQRT_STEPS+1];

  assign rr_rem[0]  = r2;
  assign rr_root[0] = '0;
  assign dd_rem[0]  = d2;
  assign dd_root[0] = '0;
  assign sq_side[0] = side5;

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
    rpr_sqrt_cell #(.BIT(SQRT_STEPS - 1 - g)) u_r (
      .clk      (clk),
      .en       (en),
      .rem_in   (rr_rem[g]),
      .root_in  (rr_root[g]),
      .rem_out  (rr_rem[g+1]),
      .root_out (rr_root[g+1])
    );
    rpr_sqrt_cell #(.BIT(SQRT_STEPS - 1 - g)) u_d (
      .clk      (clk),
      .en       (en),
      .rem_in   (dd_rem[g]),
      .root_in  (dd_root[g]),
      .rem_out  (dd_rem[g+1]),
      .root_out (dd_root[g+1])
    );
    always_ff @(posedge clk) begin
      if (en) sq_side[g+1] <= sq_side[g];
    end
  end

  // scale by range, then add half the divisor
  logic [63:0] mx, my;
  logic [31:0] den_m;
  sq_side_t    side_m;
  logic [63:0] nx, ny;
  logic [31:0] den_n;
  dv_side_t    side_n;

  always_ff @(posedge clk) begin
    if (en) begin
      mx     <= {32'b0, sq_side[SQRT_STEPS].mag_x} * {32'b0, rr_root[SQRT_STEPS]};
      my     <= {32'b0, sq_side[SQRT_STEPS].mag_y} * {32'b0, rr_root[SQRT_STEPS]};
      den_m  <= dd_root[SQRT_STEPS];
      side_m <= sq_side[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx           <= mx + {33'b0, den_m[31:1]};
      ny           <= my + {33'b0, den_m[31:1]};
      den_n        <= den_m;
      side_n.neg_x <= side_m.neg_x;
      side_n.neg_y <= side_m.neg_y;
      side_n.meas_x <= side_m.meas_x;
      side_n.meas_y <= side_m.meas_y;
      side_n.degen <= side_m.degen;
      side_n.sat   <= side_m.sat;
      side_n.ovf_x <= {9'b0, mx + {33'b0, den_m[31:1]}} >= {den_m, 41'b0};
      side_n.ovf_y <= {9'b0, my + {33'b0, den_m[31:1]}} >= {den_m, 41'b0};
    end
  end

  // divider chains
  logic [31:0] xden [DIV_STEPS+1];
  logic [63:0] xrem [DIV_STEPS+1];
  logic [40:0] xquo [DIV_STEPS+1];
  logic [31:0] yden [DIV_STEPS+1];
  logic [63:0] yrem [DIV_STEPS+1];
  logic [40:0] yquo [DIV_STEPS+1];
  dv_side_t    dv_side [DIV_STEPS+1];

  assign xden[0]    = den_n;
  assign xrem[0]    = nx;
  assign xquo[0]    = '0;
  assign yden[0]    = den_n;
  assign yrem[0]    = ny;
  assign yquo[0]    = '0;
  assign dv_side[0] = side_n;

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    rpr_div_cell #(.BIT(DIV_STEPS - 1 - g)) u_x (
      .clk     (clk),
      .en      (en),
      .den_in  (xden[g]),
      .rem_in  (xrem[g]),
      .quo_in  (xquo[g]),
      .den_out (xden[g+1]),
      .rem_out (xrem[g+1]),
      .quo_out (xquo[g+1])
    );
    rpr_div_cell #(.BIT(DIV_STEPS - 1 - g)) u_y (
      .clk     (clk),
      .en      (en),
      .den_in  (yden[g]),
      .rem_in  (yrem[g]),
      .quo_in  (yquo[g]),
      .den_out (yden[g+1]),
      .rem_out (yrem[g+1]),
      .quo_out (yquo[g+1])
    );
    always_ff @(posedge clk) begin
      if (en) dv_side[g+1] <= dv_side[g];
    end
  end

  // residuals
  dv_side_t           fin;
  logic [40:0]        qx, qy;
  logic signed [42:0] px, py, ex, ey;
  coord_t             res_x_next, res_y_next;
  logic               clip_x, clip_y;
  coord_t             res_x, res_y;
  logic               res_degen, res_sat;

  assign fin = dv_side[DIV_STEPS];
  assign qx  = (fin.ovf_x || xquo[DIV_STEPS] > PROJ_LIMIT) ? PROJ_LIMIT : xquo[DIV_STEPS];
  assign qy  = (fin.ovf_y || yquo[DIV_STEPS] > PROJ_LIMIT) ? PROJ_LIMIT : yquo[DIV_STEPS];
  assign px  = fin.neg_x ? -$signed({2'b0, qx}) : $signed({2'b0, qx});
  assign py  = fin.neg_y ? -$signed({2'b0, qy}) : $signed({2'b0, qy});
  assign ex  = 43'(fin.meas_x) - px;
  assign ey  = 43'(fin.meas_y) - py;

  always_comb begin
    clip_x = 1'b0;
    clip_y = 1'b0;
    if (ex > 43'sd2147483647) begin
      res_x_next = 32'sh7fff_ffff;
      clip_x     = 1'b1;
    end else if (ex < -43'sd2147483648) begin
      res_x_next = 32'sh8000_0000;
      clip_x     = 1'b1;
    end else begin
      res_x_next = ex[31:0];
    end
    if (ey > 43'sd2147483647) begin
      res_y_next = 32'sh7fff_ffff;
      clip_y     = 1'b1;
    end else if (ey < -43'sd2147483648) begin
      res_y_next = 32'sh8000_0000;
      clip_y     = 1'b1;
    end else begin
      res_y_next = ey[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_degen <= fin.degen;
      if (fin.degen) begin
        res_x   <= '0;
        res_y   <= '0;
        res_sat <= fin.sat;
      end else begin
        res_x   <= res_x_next;
        res_y   <= res_y_next;
        res_sat <= fin.sat | clip_x | clip_y;
      end
    end
  end

  // output register and skid
  logic [OUT_W-1:0]  res_data, skid_data;
  logic [USER_W-1:0] res_user, skid_user;
  logic              res_v;

  assign res_data = {res_y, res_x};
  assign res_user = {res_sat, res_degen};
  assign res_v    = vld[PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      skid_v        <= 1'b0;
    end else if (!m_axis_tvalid || m_axis_tready) begin
      if (skid_v) begin
        m_axis_tvalid <= 1'b1;
        skid_v        <= 1'b0;
      end else begin
        m_axis_tvalid <= res_v;
      end
    end else if (res_v && en) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_axis_tvalid || m_axis_tready) begin
      m_axis_tdata <= skid_v ? skid_data : res_data;
      m_axis_tuser <= skid_v ? skid_user : res_user;
    end else if (res_v && en) begin
      skid_data <= res_data;
      skid_user <= res_user;
    end
  end

endmodule

### sv/rpr_checker.sv
// port checks for the radar point residual unit, bound to the top level
module rpr_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [rpr_pkg::OUT_W-1:0]     m_axis_tdata,
  input logic [rpr_pkg::USER_W-1:0]    m_axis_tuser
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled output item changed");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("degenerate item with nonzero residual");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with no output pending");

endmodule

bind radar_point_residual_unit rpr_checker u_rpr_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
